/* hw/rtl/circular_list_cursor_engine_core_assert.svh */
// Assertion macros used by the port checker.
`ifndef CIRCULAR_LIST_CURSOR_ENGINE_CORE_ASSERT_SVH
`define CIRCULAR_LIST_CURSOR_ENGINE_CORE_ASSERT_SVH
// Check that a property holds on every clock edge outside reset.
`define CLCE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a property holds on every clock edge, reset included.
`define CLCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* hw/rtl/clce_pkg.sv */
// Package with command, status and controller types of the list cursor engine.
package clce_pkg;
    typedef enum logic [2:0] {
        KIND_INS_BEFORE = 3'd0,
        KIND_INS_AFTER  = 3'd1,
        KIND_DELETE     = 3'd2,
        KIND_ADVANCE    = 3'd3,
        KIND_SEARCH     = 3'd4,
        KIND_CLEAR      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_INS_FIX,
        S_DEL_RD,
        S_DEL_WR,
        S_MOD,
        S_WALK,
        S_SRCH,
        S_FIN_RD,
        S_FIN,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic ins_wr;     // take a free node, write its value and own links
        logic ins_fix;    // patch the neighbor links and move the cursor
        logic del_wr;     // unlink the current node and recycle it
        logic mod_start;  // start step modulo reduction
        logic mod_step;   // one restoring subtract step
        logic walk_step;  // move cursor one link, alternating read and move phases
        logic srch_start; // start the search at the cursor
        logic srch_step;  // read, then compare and move
        logic do_clear;   // reset pool bookkeeping
        logic out_load;   // load output register
        status_t st;      // status for output
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic    empty;
        logic    full;
        logic    mod_done;
        logic    walk_done;
        logic    srch_hit;
        logic    srch_done;
        kind_t   kind;
    } dp_stat_t;
endpackage

/* hw/rtl/clce_ram.sv */
// Generic single write, single read RAM with registered read data.
module clce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/clce_ctrl.sv */
// Controller state machine of the list cursor engine.
module clce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              out_valid,
    input  logic              out_stall,
    input  clce_pkg::dp_stat_t stat,
    output clce_pkg::dp_cmd_t  cmd
);
    clce_pkg::state_t state_reg, state_next;
    clce_pkg::status_t st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clce_pkg::S_IDLE;
            st_reg    <= clce_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        unique case (state_reg)
            clce_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = clce_pkg::S_DECODE;
                end
            end
            clce_pkg::S_DECODE:
            begin
                st_next    = clce_pkg::ST_OK;
                state_next = clce_pkg::S_FIN_RD;
                unique case (stat.kind)
                    clce_pkg::KIND_INS_BEFORE, clce_pkg::KIND_INS_AFTER:
                    begin
                        if (stat.full)
                        begin
                            st_next = clce_pkg::ST_FULL;
                        end
                        else
                        begin
                            state_next = clce_pkg::S_INS_RD;
                        end
                    end
                    clce_pkg::KIND_DELETE, clce_pkg::KIND_ADVANCE, clce_pkg::KIND_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            st_next = clce_pkg::ST_EMPTY;
                        end
                        else if (stat.kind == clce_pkg::KIND_DELETE)
                        begin
                            state_next = clce_pkg::S_DEL_RD;
                        end
                        else if (stat.kind == clce_pkg::KIND_ADVANCE)
                        begin
                            state_next = clce_pkg::S_MOD;
                        end
                        else
                        begin
                            state_next = clce_pkg::S_SRCH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            clce_pkg::S_INS_RD:  state_next = clce_pkg::S_INS_WR;
            clce_pkg::S_INS_WR:  state_next = clce_pkg::S_INS_FIX;
            clce_pkg::S_INS_FIX: state_next = clce_pkg::S_FIN_RD;
            clce_pkg::S_DEL_RD:  state_next = clce_pkg::S_DEL_WR;
            clce_pkg::S_DEL_WR:  state_next = clce_pkg::S_FIN_RD;
            clce_pkg::S_MOD:
            begin
                if (stat.mod_done)
                begin
                    state_next = clce_pkg::S_WALK;
                end
            end
            clce_pkg::S_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = clce_pkg::S_FIN_RD;
                end
            end
            clce_pkg::S_SRCH:
            begin
                if (stat.srch_hit)
                begin
                    state_next = clce_pkg::S_FIN_RD;
                end
                else if (stat.srch_done)
                begin
                    st_next    = clce_pkg::ST_NOTFOUND;
                    state_next = clce_pkg::S_FIN_RD;
                end
            end
            clce_pkg::S_FIN_RD: state_next = clce_pkg::S_FIN;
            clce_pkg::S_FIN:    state_next = clce_pkg::S_OUT;
            clce_pkg::S_OUT:
            begin
                if (!out_valid || !out_stall)
                begin
                    state_next = clce_pkg::S_IDLE;
                end
            end
            default: state_next = clce_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd           = '0;
        cmd.st        = st_reg;
        in_stall      = (state_reg != clce_pkg::S_IDLE);
        cmd.load      = (state_reg == clce_pkg::S_IDLE) && in_valid;
        unique case (state_reg)
            clce_pkg::S_DECODE:
            begin
                cmd.do_clear   = (stat.kind == clce_pkg::KIND_CLEAR);
                cmd.mod_start  = (stat.kind == clce_pkg::KIND_ADVANCE);
                cmd.srch_start = (stat.kind == clce_pkg::KIND_SEARCH);
            end
            clce_pkg::S_INS_WR:  cmd.ins_wr    = 1'b1;
            clce_pkg::S_INS_FIX: cmd.ins_fix   = 1'b1;
            clce_pkg::S_DEL_WR:  cmd.del_wr    = 1'b1;
            clce_pkg::S_MOD:     cmd.mod_step  = 1'b1;
            clce_pkg::S_WALK:    cmd.walk_step = 1'b1;
            clce_pkg::S_SRCH:    cmd.srch_step = 1'b1;
            clce_pkg::S_OUT:     cmd.out_load  = !out_valid || !out_stall;
            default:
            begin
            end
        endcase
    end
endmodule

/* hw/rtl/clce_dp.sv */
// Datapath of the list cursor engine: node memories, free stack, cursor, walk units.
module clce_dp #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32,
    parameter int STEP_BITS  = 16,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int DW = STEP_BITS + CW,
    localparam int SW = $clog2(STEP_BITS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [2:0]            kind,
    input  logic [VALUE_BITS-1:0] tag_value,
    input  logic [STEP_BITS-1:0]  step_count,
    input  clce_pkg::dp_cmd_t     cmd,
    output clce_pkg::dp_stat_t    stat,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [VALUE_BITS-1:0] current_value,
    output logic                  current_valid,
    output logic [CW-1:0]         element_count
);
    logic [2:0]            kind_reg;
    logic [VALUE_BITS-1:0] tag_reg;
    logic                  neg_reg;
    logic [STEP_BITS-1:0]  rem_reg, rem_next;    // magnitude being reduced
    logic [DW-1:0]         divs_reg;             // element count shifted under rem_reg
    logic [SW-1:0]         sh_reg;
    logic [CW-1:0]         walk_reg;             // steps left, or nodes visited
    logic                  ph_reg;               // read phase of a walk or search step
    logic [AW-1:0]         cur_reg, node_reg, nb_reg;
    logic                  fix_reg;
    logic [CW-1:0]         fresh_reg;            // nodes handed out fresh since clear
    logic [CW-1:0]         rtop_reg;             // nodes on the recycle stack
    logic [CW-1:0]         total_reg;

    // Memories: values, next, prev, recycle stack.
    logic                  v_we, n_we, p_we, f_we;
    logic [AW-1:0]         v_wa, n_wa, p_wa, f_wa, v_ra, n_ra, p_ra, f_ra;
    logic [VALUE_BITS-1:0] v_wd, v_rd;
    logic [AW-1:0]         n_wd, p_wd, f_wd, n_rd, p_rd, f_rd;

    clce_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (.clk, .we(v_we), .waddr(v_wa),
        .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
    clce_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_nxt (.clk, .we(n_we), .waddr(n_wa),
        .wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
    clce_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prv (.clk, .we(p_we), .waddr(p_wa),
        .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
    clce_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_fre (.clk, .we(f_we), .waddr(f_wa),
        .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

    // Allocate from the recycle stack first, else the next never used node.
    // The stack only ever holds written entries, so no clearing pass is needed.
    logic [AW-1:0] new_node;
    assign new_node = (rtop_reg != '0) ? f_rd : AW'(fresh_reg);

    logic srch_hit;
    assign srch_hit = (v_rd == tag_reg);

    always_comb
    begin
        v_we = 1'b0; n_we = 1'b0; p_we = 1'b0; f_we = 1'b0;
        v_wa = new_node; n_wa = new_node; p_wa = new_node; f_wa = AW'(rtop_reg);
        v_wd = tag_reg; n_wd = new_node; p_wd = new_node; f_wd = cur_reg;
        v_ra = cur_reg; n_ra = cur_reg; p_ra = cur_reg; f_ra = AW'(rtop_reg - CW'(1));
        if (cmd.srch_step)
        begin
            v_ra = node_reg;
            n_ra = node_reg;
        end
        if (cmd.ins_wr)
        begin
            v_we = 1'b1;
            n_we = 1'b1;
            p_we = 1'b1;
            if (total_reg == '0)
            begin
                n_wd = new_node;
                p_wd = new_node;
            end
            else if (kind_reg == clce_pkg::KIND_INS_AFTER)
            begin
                n_wd = n_rd;
                p_wd = cur_reg;
            end
            else
            begin
                n_wd = cur_reg;
                p_wd = p_rd;
            end
        end
        if (cmd.ins_fix && fix_reg)
        begin
            n_we = 1'b1;
            p_we = 1'b1;
            n_wd = node_reg;
            p_wd = node_reg;
            if (kind_reg == clce_pkg::KIND_INS_AFTER)
            begin
                p_wa = nb_reg;
                n_wa = cur_reg;
            end
            else
            begin
                n_wa = nb_reg;
                p_wa = cur_reg;
            end
        end
        if (cmd.del_wr)
        begin
            // prev[next] = prev, next[prev] = next, push the node
            p_we = 1'b1; p_wa = n_rd; p_wd = p_rd;
            n_we = 1'b1; n_wa = p_rd; n_wd = n_rd;
            f_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= '0;
            rtop_reg  <= '0;
            total_reg <= '0;
            cur_reg   <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
            if (cmd.do_clear && total_reg != '0)
            begin
                fresh_reg <= '0;
                rtop_reg  <= '0;
                total_reg <= '0;
                cur_reg   <= '0;
            end
            if (cmd.ins_wr)
            begin
                if (rtop_reg != '0)
                begin
                    rtop_reg <= rtop_reg - CW'(1);
                end
                else
                begin
                    fresh_reg <= fresh_reg + CW'(1);
                end
                total_reg <= total_reg + CW'(1);
            end
            if (cmd.ins_fix)
            begin
                cur_reg <= node_reg;
            end
            if (cmd.del_wr)
            begin
                rtop_reg  <= rtop_reg + CW'(1);
                total_reg <= total_reg - CW'(1);
                cur_reg   <= (total_reg == CW'(1)) ? '0 : p_rd;
            end
            if (cmd.walk_step && walk_reg != '0 && ph_reg)
            begin
                cur_reg <= neg_reg ? p_rd : n_rd;
            end
            if (cmd.srch_step && ph_reg && srch_hit)
            begin
                cur_reg <= node_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            tag_reg  <= tag_value;
            neg_reg  <= step_count[STEP_BITS-1];
            rem_reg  <= step_count[STEP_BITS-1] ? (~step_count + STEP_BITS'(1)) : step_count;
        end
        if (cmd.ins_wr)
        begin
            node_reg <= new_node;
            nb_reg   <= (kind_reg == clce_pkg::KIND_INS_AFTER) ? n_rd : p_rd;
            fix_reg  <= (total_reg != '0);
        end
        if (cmd.mod_start)
        begin
            // Align divisor under the magnitude: start at the top bit.
            divs_reg <= DW'(total_reg) << (STEP_BITS - 1);
            sh_reg   <= '0;
            ph_reg   <= 1'b0;
        end
        if (cmd.mod_step)
        begin
            rem_reg  <= rem_next;
            divs_reg <= divs_reg >> 1;
            sh_reg   <= sh_reg + SW'(1);
            walk_reg <= CW'(rem_next);
        end
        if (cmd.walk_step && walk_reg != '0)
        begin
            if (ph_reg)
            begin
                walk_reg <= walk_reg - CW'(1);
            end
            ph_reg <= !ph_reg;
        end
        if (cmd.srch_start)
        begin
            node_reg <= cur_reg;
            walk_reg <= '0;
            ph_reg   <= 1'b0;
        end
        if (cmd.srch_step)
        begin
            ph_reg <= !ph_reg;
            if (ph_reg)
            begin
                node_reg <= n_rd;
                walk_reg <= walk_reg + CW'(1);
            end
        end
        if (cmd.out_load)
        begin
            status        <= cmd.st;
            current_valid <= (total_reg != '0);
            current_value <= (total_reg != '0) ? v_rd : '0;
            element_count <= total_reg;
        end
    end

    // Restoring reduction: one compare and subtract per cycle.
    always_comb
    begin
        rem_next = rem_reg;
        if (DW'(rem_reg) >= divs_reg)
        begin
            rem_next = STEP_BITS'(DW'(rem_reg) - divs_reg);
        end
    end

    assign stat.kind      = clce_pkg::kind_t'(kind_reg);
    assign stat.empty     = (total_reg == '0);
    assign stat.full      = (total_reg == CW'(CAPACITY));
    assign stat.mod_done  = (sh_reg == SW'(STEP_BITS - 1));
    assign stat.walk_done = (walk_reg == '0);
    assign stat.srch_hit  = ph_reg && srch_hit;
    assign stat.srch_done = ph_reg && (walk_reg == total_reg - CW'(1));
endmodule

/* hw/rtl/circular_list_cursor_engine_core.sv */
// Circular doubly linked list cursor engine: one command in, one result out.
// The list lives in a node pool of CAPACITY entries held in four small RAMs
// (values, next links, prev links, recycle stack), each with a registered
// read. One command is taken at a time. Insert runs through decode, a read
// of the links around the cursor, the write of the new node, the neighbor
// patch, and a read of the current value. Delete runs through decode, a
// read of the links, the unlink and a read of the current value. Clear, a
// full insert, an empty list and unused kinds go from decode to that read.
// Advance first reduces the step count modulo the element count with one
// restoring subtract per cycle, then walks one link per read and move
// phase pair. Search reads, then compares and moves on, one node at a time
// from the cursor until a hit or a full lap. The result sits in an output
// register until it is taken; a result still waiting there holds the next
// one back. Free nodes come from a recycle stack of deleted nodes first,
// then from a count of never used nodes, so no clearing pass runs after reset.
module circular_list_cursor_engine_core #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32,
    parameter int STEP_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        kind,
    input  logic [VALUE_BITS-1:0]             tag_value,
    input  logic signed [STEP_BITS-1:0]       step_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [VALUE_BITS-1:0]             current_value,
    output logic                              current_valid,
    output logic [$clog2(CAPACITY+1)-1:0]     element_count
);
    clce_pkg::dp_cmd_t  cmd;
    clce_pkg::dp_stat_t stat;

    clce_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
    );

    clce_dp #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS), .STEP_BITS(STEP_BITS)) u_dp (
        .clk, .rst_n, .kind, .tag_value, .step_count(STEP_BITS'(step_count)), .cmd, .stat,
        .out_valid, .out_stall, .status, .current_value, .current_valid, .element_count
    );
endmodule

/* hw/rtl/clce_checker.sv */
// Port checker for the list cursor engine and its bind.
`include "circular_list_cursor_engine_core_assert.svh"
module clce_checker #(
    parameter int CW = 7
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input logic [1:0]    status,
    input logic          current_valid,
    input logic [CW-1:0] element_count
);
    `CLCE_ASSERT(a_valid_cnt, clk, rst_n,
        out_valid |-> (current_valid == (element_count != '0)),
        "valid flag disagrees with count")
    `CLCE_ASSERT(a_hold, clk, rst_n,
        (out_valid && out_stall) |=> (out_valid && $stable(status)),
        "result dropped while stalled")
    `CLCE_ASSERT(a_busy, clk, rst_n,
        (in_valid && !in_stall) |=> in_stall,
        "second item taken during work")
    `CLCE_ASSERT(a_full_nz, clk, rst_n,
        (out_valid && status == clce_pkg::ST_FULL) |-> (element_count != '0),
        "full with empty list")
endmodule

bind circular_list_cursor_engine_core clce_checker #(.CW($clog2(CAPACITY+1))) u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .status,
    .current_valid, .element_count
);

/* tb/sv/circular_list_cursor_engine_core_checker.sv */
// Checker: watches both channels, models the list and compares each result.
module circular_list_cursor_engine_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] tag_value,
    input  logic signed [15:0] step_count,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [31:0] current_value,
    input  logic        current_valid,
    input  logic [6:0]  element_count,
    output int          fail_count,
    output int          pending_count
);
    typedef struct packed {
        clce_pkg::status_t st;
        logic [31:0]       val;
        logic              vld;
        logic [6:0]        cnt;
    } list_result_t;

    logic [31:0] tag_mem [64];
    logic [5:0]  nxt_mem [64];
    logic [5:0]  prv_mem [64];
    logic [5:0]  free_mem [64];
    int          free_ptr;
    logic [5:0]  cur_node;
    int          node_cnt;
    list_result_t result_q [$];

    function automatic void free_all();
        for (int i = 0; i < 64; i++) free_mem[i] = 6'(i);
        free_ptr = 64;
        cur_node = '0;
        node_cnt = 0;
    endfunction

    function automatic list_result_t apply_command(logic [2:0] k, logic [31:0] t,
                                                   logic signed [15:0] s);
        list_result_t r;
        logic [5:0]   n, nb, p, c;
        int           mag, steps;
        bit           hit;
        r.st = clce_pkg::ST_OK;
        case (k)
            clce_pkg::KIND_INS_BEFORE, clce_pkg::KIND_INS_AFTER:
            begin
                if (free_ptr == 0) r.st = clce_pkg::ST_FULL;
                else
                begin
                    free_ptr--;
                    n = free_mem[free_ptr];
                    tag_mem[n] = t;
                    if (node_cnt == 0)
                    begin
                        nxt_mem[n] = n;
                        prv_mem[n] = n;
                    end
                    else if (k == clce_pkg::KIND_INS_AFTER)
                    begin
                        nb = nxt_mem[cur_node];
                        nxt_mem[n] = nb;
                        prv_mem[n] = cur_node;
                        prv_mem[nb] = n;
                        nxt_mem[cur_node] = n;
                    end
                    else
                    begin
                        nb = prv_mem[cur_node];
                        prv_mem[n] = nb;
                        nxt_mem[n] = cur_node;
                        nxt_mem[nb] = n;
                        prv_mem[cur_node] = n;
                    end
                    cur_node = n;
                    node_cnt++;
                end
            end
            clce_pkg::KIND_DELETE:
            begin
                if (node_cnt == 0) r.st = clce_pkg::ST_EMPTY;
                else
                begin
                    c = cur_node;
                    if (node_cnt == 1) cur_node = '0;
                    else
                    begin
                        p = prv_mem[c];
                        n = nxt_mem[c];
                        prv_mem[n] = p;
                        nxt_mem[p] = n;
                        cur_node = p;
                    end
                    free_mem[free_ptr] = c;
                    free_ptr++;
                    node_cnt--;
                end
            end
            clce_pkg::KIND_ADVANCE:
            begin
                if (node_cnt == 0) r.st = clce_pkg::ST_EMPTY;
                else
                begin
                    mag = (s < 0) ? -int'(s) : int'(s);
                    steps = mag % node_cnt;
                    repeat (steps) cur_node = (s < 0) ? prv_mem[cur_node] : nxt_mem[cur_node];
                end
            end
            clce_pkg::KIND_SEARCH:
            begin
                if (node_cnt == 0) r.st = clce_pkg::ST_EMPTY;
                else
                begin
                    c = cur_node;
                    hit = 0;
                    for (int i = 0; i < node_cnt && !hit; i++)
                    begin
                        if (tag_mem[c] == t) hit = 1;
                        else c = nxt_mem[c];
                    end
                    if (hit) cur_node = c;
                    else r.st = clce_pkg::ST_NOTFOUND;
                end
            end
            clce_pkg::KIND_CLEAR: if (node_cnt != 0) free_all();
            default: ;
        endcase
        r.vld = (node_cnt != 0);
        r.val = r.vld ? tag_mem[cur_node] : '0;
        r.cnt = 7'(node_cnt);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_r;
        if (!rst_n)
        begin
            free_all();
            result_q.delete();
            pending_count = 0;
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                result_q.push_back(apply_command(kind, tag_value, step_count));
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    if (fail_count < 10) $display("unexpected result transfer");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (status !== exp_r.st || current_value !== exp_r.val
                        || current_valid !== exp_r.vld || element_count !== exp_r.cnt)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch: exp st=%0d val=%h vld=%b cnt=%0d ",
                                      "got st=%0d val=%h vld=%b cnt=%0d"},
                                     exp_r.st, exp_r.val, exp_r.vld, exp_r.cnt,
                                     status, current_value, current_valid, element_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count = result_q.size();
        end
    end
endmodule

/* tb/sv/circular_list_cursor_engine_core_tb.sv */
// Testbench top: drives commands and result stalls, reports the verdict.
module circular_list_cursor_engine_core_tb;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [2:0]  kind = '0;
    logic [31:0] tag_value = '0;
    logic signed [15:0] step_count = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [1:0]  status;
    logic [31:0] current_value;
    logic        current_valid;
    logic [6:0]  element_count;
    int          fail_count;
    int          pending_count;
    bit          calm_phase = 0;

    // Tags inserted since the last clear; search draws from these to get hits.
    logic [31:0] tag_pool [$];

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    circular_list_cursor_engine_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .tag_value(tag_value), .step_count(step_count),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .current_value(current_value),
        .current_valid(current_valid), .element_count(element_count)
    );

    circular_list_cursor_engine_core_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .tag_value(tag_value), .step_count(step_count),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .current_value(current_value),
        .current_valid(current_valid), .element_count(element_count),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Send one command: optionally hold off in a burst, then present it and
    // wait for the transfer. Valid stays high back to back when no gap is drawn.
    task automatic send_cmd(clce_pkg::kind_t k, logic [31:0] t, logic signed [15:0] s);
        if (!calm_phase && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1;
        kind <= k;
        tag_value <= t;
        step_count <= s;
        if (k == clce_pkg::KIND_INS_BEFORE || k == clce_pkg::KIND_INS_AFTER)
            tag_pool.push_back(t);
        if (k == clce_pkg::KIND_CLEAR) tag_pool.delete();
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Result side: stall in random bursts, none in the calm phase.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm_phase && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_stall <= 0;
        end
    end

    function automatic logic [31:0] pick_tag();
        if (tag_pool.size() != 0 && $urandom_range(0, 2) != 0)
            return tag_pool[$urandom_range(0, tag_pool.size() - 1)];
        return $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 7)) : $urandom();
    endfunction

    initial
    begin
        clce_pkg::kind_t k;
        int              r;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty-list cases, extremes, single node delete, full pool.
        send_cmd(clce_pkg::KIND_DELETE, '0, '0);
        send_cmd(clce_pkg::KIND_ADVANCE, '0, 16'sd5);
        send_cmd(clce_pkg::KIND_SEARCH, 32'h1, '0);
        send_cmd(clce_pkg::KIND_CLEAR, '0, '0);
        send_cmd(clce_pkg::kind_t'(3'd6), '0, '0);
        send_cmd(clce_pkg::kind_t'(3'd7), '1, '1);
        send_cmd(clce_pkg::KIND_INS_AFTER, 32'hFFFF_FFFF, '0);
        send_cmd(clce_pkg::KIND_DELETE, '0, '0);
        send_cmd(clce_pkg::KIND_INS_BEFORE, 32'h0, '0);
        send_cmd(clce_pkg::KIND_INS_AFTER, 32'hA5A5_5A5A, '0);
        send_cmd(clce_pkg::KIND_INS_BEFORE, 32'hFFFF_FFFF, '0);
        send_cmd(clce_pkg::KIND_ADVANCE, '0, 16'sh7FFF);
        send_cmd(clce_pkg::KIND_ADVANCE, '0, -16'sh8000);
        send_cmd(clce_pkg::KIND_ADVANCE, '0, -16'sd1);
        send_cmd(clce_pkg::KIND_ADVANCE, '0, 16'sd0);
        send_cmd(clce_pkg::KIND_SEARCH, 32'h0, '0);
        send_cmd(clce_pkg::KIND_SEARCH, 32'h1234_5678, '0);
        send_cmd(clce_pkg::KIND_DELETE, '0, '0);
        send_cmd(clce_pkg::KIND_CLEAR, '0, '0);
        // Fill the pool and overflow it.
        repeat (66) send_cmd(clce_pkg::KIND_INS_AFTER, $urandom(), 16'($urandom()));
        send_cmd(clce_pkg::KIND_ADVANCE, '0, 16'sd100);
        send_cmd(clce_pkg::KIND_CLEAR, '0, '0);

        // Random: inserts most often, then deletes, searches and walks, rare clears.
        for (int i = 0; i < 860; i++)
        begin
            if (i >= 780) calm_phase = 1;
            r = $urandom_range(0, 99);
            if (r < 22) k = clce_pkg::KIND_INS_BEFORE;
            else if (r < 44) k = clce_pkg::KIND_INS_AFTER;
            else if (r < 62) k = clce_pkg::KIND_DELETE;
            else if (r < 78) k = clce_pkg::KIND_ADVANCE;
            else if (r < 95) k = clce_pkg::KIND_SEARCH;
            else if (r < 97) k = clce_pkg::KIND_CLEAR;
            else k = clce_pkg::kind_t'(3'($urandom_range(6, 7)));
            send_cmd(k, pick_tag(),
                     $urandom_range(0, 3) == 0 ? 16'($urandom()) :
                                                 16'(int'($urandom_range(0, 20)) - 10));
        end
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("circular_list_cursor_engine_core_tb: PASS");
        else
            $display("circular_list_cursor_engine_core_tb: FAIL");
        $finish;
    end

    // Watchdog: the slowest command (an advance), plus gaps and stalls, over
    // every item still fits many times inside.
    initial
    begin
        #20000000;
        $display("circular_list_cursor_engine_core_tb: FAIL");
        $finish;
    end
endmodule
